[rtl/core/lrcs_pkg.sv]
package lrcs_pkg;

  localparam int unsigned LABEL_BITS = 8;
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned NUM_LABELS = 1 << LABEL_BITS;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned CNT_W      = 30;
  localparam int unsigned SUM_W      = 64;
  // product of a zero-extended index and a Q16.16 step
  localparam int unsigned PROD_W     = 32 + INDEX_BITS + 1;
  // origin plus three products
  localparam int unsigned XPOS_W     = PROD_W + 2;
  localparam int unsigned PP_W       = 32 + CNT_W;
  localparam int unsigned WPROD_W    = SUM_W + CNT_W;
  localparam int unsigned ADDR_W     = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes
  localparam logic [1:0] REG_X_ORIGIN = 2'd0;
  localparam logic [1:0] REG_X_STEP_I = 2'd1;
  localparam logic [1:0] REG_X_STEP_J = 2'd2;
  localparam logic [1:0] REG_X_STEP_K = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[rtl/core/label_rank_and_centroid_sort_unit.sv]
// Channel | Direction | Handshake            | Beat
// voxel   | in        | start_i / busy_o     | label, index i/j/k, last flag
// result  | out       | done_o (one cycle)   | pelvis, left femur, right femur ids
// config  | in/out    | APB psel/penable     | x origin and x steps, Q16.16
//
// Voxels enter through a three-stage pipe: input register, index products with the RAM
// read, then x position and the count/sum update, forwarded from the previous write.
// After the last voxel busy_o stays high through the three pipe stages,
// NUM_LABELS - 1 RAM reads to rank, a drain state and five compare steps.
// done_o pulses once on the cycle busy_o drops; the receiver cannot stall it.
// Reset clears the per-label valid bits, so the RAM needs no clearing pass.
module label_rank_and_centroid_sort_unit
  import lrcs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [7:0]            voxel_label_i,
  input  logic [9:0]            index_i_i,
  input  logic [9:0]            index_j_i,
  input  logic [9:0]            index_k_i,
  input  logic                  last_voxel_i,
  output logic                  done_o,
  output logic [7:0]            pelvis_id_o,
  output logic [7:0]            left_femur_id_o,
  output logic [7:0]            right_femur_id_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SDRN = 3'd2;
  localparam logic [2:0] ST_NEG  = 3'd3;
  localparam logic [2:0] ST_MLO  = 3'd4;
  localparam logic [2:0] ST_MHI  = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_CMP  = 3'd7;

  // config
  logic signed [31:0] x_origin_q, x_step_i_q, x_step_j_q, x_step_k_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      x_step_i_q <= 32'sd65536;
      x_step_j_q <= '0;
      x_step_k_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_X_ORIGIN: x_origin_q <= pwdata;
        REG_X_STEP_I: x_step_i_q <= pwdata;
        REG_X_STEP_J: x_step_j_q <= pwdata;
        REG_X_STEP_K: x_step_k_q <= pwdata;
        default:      x_origin_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_ORIGIN: prdata = x_origin_q;
      REG_X_STEP_I: prdata = x_step_i_q;
      REG_X_STEP_J: prdata = x_step_j_q;
      REG_X_STEP_K: prdata = x_step_k_q;
      default:      prdata = x_origin_q;
    endcase
  end

  // control
  logic [2:0]            st_q, st_d;
  logic                  last_inflight_q;
  logic                  accept;
  logic                  a_v_q, b_v_q, c_v_q;
  logic                  a_last_q, b_last_q, c_last_q;
  logic [LABEL_BITS-1:0] a_lab_q, b_lab_q, c_lab_q;
  logic [INDEX_BITS-1:0] a_i_q, a_j_q, a_k_q;
  logic signed [PROD_W-1:0] p_i_q, p_j_q, p_k_q;
  logic signed [XPOS_W-1:0] x_q;

  assign busy_o = last_inflight_q || (st_q != ST_RUN);
  assign accept = start_i && !busy_o;

  // RAM port
  logic                  ram_re, ram_we;
  logic [LABEL_BITS-1:0] ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_ent, cur_ent, upd_ent;

  logic [LABEL_BITS-1:0] scan_q;
  logic                  rd_v_q;
  logic [LABEL_BITS-1:0] rd_lab_q;
  logic [NUM_LABELS-1:0] vld_q;
  logic                  wr_v_q;
  logic [LABEL_BITS-1:0] wr_lab_q;
  entry_t                wr_ent_q;

  assign ram_re    = (st_q == ST_SCAN) || b_v_q;
  assign ram_raddr = (st_q == ST_SCAN) ? scan_q : b_lab_q;
  assign ram_we    = c_v_q;
  assign rd_ent    = ram_rdata;

  always_comb begin
    if (wr_v_q && (wr_lab_q == c_lab_q)) begin
      cur_ent = wr_ent_q;
    end else if (vld_q[c_lab_q]) begin
      cur_ent = rd_ent;
    end else begin
      cur_ent = '0;
    end
    upd_ent.cnt = (cur_ent.cnt != CNT_MAX) ? cur_ent.cnt + 1'b1 : cur_ent.cnt;
    upd_ent.sum = cur_ent.sum + SUM_W'(x_q);
  end

  lrcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LABELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_lab_q),
    .wdata_i (upd_ent),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ranking: top three by count, strict compare keeps the lowest label on ties
  logic [CNT_W-1:0]      cnt1_q, cnt2_q, cnt3_q;
  logic [LABEL_BITS-1:0] lab1_q, lab2_q, lab3_q;
  logic [SUM_W-1:0]      sum1_q, sum2_q, sum3_q;
  logic [CNT_W-1:0]      scan_cnt;

  assign scan_cnt = vld_q[rd_lab_q] ? rd_ent.cnt : '0;

  // mean compare: sum2*cnt3 against sum3*cnt2 as sign and magnitude
  logic                  neg_a_q, neg_b_q;
  logic [SUM_W-1:0]      mag_a_q, mag_b_q;
  logic [PP_W-1:0]       pa_lo_q, pb_lo_q, pa_hi_q, pb_hi_q;
  logic [WPROD_W-1:0]    pa_q, pb_q;
  logic                  an, bn, a_less, swap;

  always_comb begin
    an = neg_a_q && (pa_q != '0);
    bn = neg_b_q && (pb_q != '0);
    if (an != bn) begin
      a_less = an;
    end else if (an) begin
      a_less = pb_q < pa_q;
    end else begin
      a_less = pa_q < pb_q;
    end
    swap = (cnt2_q != '0) && (cnt3_q != '0) && a_less;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_RUN:  if (c_v_q && c_last_q) st_d = ST_SCAN;
      ST_SCAN: if (&scan_q) st_d = ST_SDRN;
      ST_SDRN: st_d = ST_NEG;
      ST_NEG:  st_d = ST_MLO;
      ST_MLO:  st_d = ST_MHI;
      ST_MHI:  st_d = ST_SUM;
      ST_SUM:  st_d = ST_CMP;
      ST_CMP:  st_d = ST_RUN;
      default: st_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ST_RUN;
      last_inflight_q <= 1'b0;
      a_v_q           <= 1'b0;
      b_v_q           <= 1'b0;
      c_v_q           <= 1'b0;
      wr_v_q          <= 1'b0;
      rd_v_q          <= 1'b0;
      vld_q           <= '0;
      done_o          <= 1'b0;
    end else begin
      st_q   <= st_d;
      a_v_q  <= accept;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      wr_v_q <= c_v_q;
      rd_v_q <= (st_q == ST_SCAN);
      done_o <= (st_q == ST_CMP);
      if (accept && last_voxel_i) begin
        last_inflight_q <= 1'b1;
      end else if (st_d == ST_SCAN && st_q == ST_RUN) begin
        last_inflight_q <= 1'b0;
      end
      if (st_q == ST_CMP) begin
        vld_q <= '0;
      end else if (c_v_q) begin
        vld_q[c_lab_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // voxel pipe
    a_lab_q  <= voxel_label_i[LABEL_BITS-1:0];
    a_i_q    <= index_i_i[INDEX_BITS-1:0];
    a_j_q    <= index_j_i[INDEX_BITS-1:0];
    a_k_q    <= index_k_i[INDEX_BITS-1:0];
    a_last_q <= last_voxel_i;
    b_lab_q  <= a_lab_q;
    b_last_q <= a_last_q;
    p_i_q    <= $signed({1'b0, a_i_q}) * x_step_i_q;
    p_j_q    <= $signed({1'b0, a_j_q}) * x_step_j_q;
    p_k_q    <= $signed({1'b0, a_k_q}) * x_step_k_q;
    c_lab_q  <= b_lab_q;
    c_last_q <= b_last_q;
    x_q      <= XPOS_W'(x_origin_q) + XPOS_W'(p_i_q) + XPOS_W'(p_j_q) + XPOS_W'(p_k_q);
    wr_lab_q <= c_lab_q;
    wr_ent_q <= upd_ent;

    // scan
    rd_lab_q <= scan_q;
    if (st_q == ST_RUN) begin
      scan_q <= LABEL_BITS'(1);
      cnt1_q <= '0; cnt2_q <= '0; cnt3_q <= '0;
      lab1_q <= '0; lab2_q <= '0; lab3_q <= '0;
      sum1_q <= '0; sum2_q <= '0; sum3_q <= '0;
    end else begin
      if (st_q == ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end
      if (rd_v_q) begin
        priority if (scan_cnt > cnt1_q) begin
          cnt1_q <= scan_cnt; lab1_q <= rd_lab_q; sum1_q <= rd_ent.sum;
          cnt2_q <= cnt1_q;   lab2_q <= lab1_q;   sum2_q <= sum1_q;
          cnt3_q <= cnt2_q;   lab3_q <= lab2_q;   sum3_q <= sum2_q;
        end else if (scan_cnt > cnt2_q) begin
          cnt2_q <= scan_cnt; lab2_q <= rd_lab_q; sum2_q <= rd_ent.sum;
          cnt3_q <= cnt2_q;   lab3_q <= lab2_q;   sum3_q <= sum2_q;
        end else if (scan_cnt > cnt3_q) begin
          cnt3_q <= scan_cnt; lab3_q <= rd_lab_q; sum3_q <= rd_ent.sum;
        end
      end
    end

    // compare steps
    if (st_q == ST_NEG) begin
      neg_a_q <= sum2_q[SUM_W-1];
      neg_b_q <= sum3_q[SUM_W-1];
      mag_a_q <= sum2_q[SUM_W-1] ? (~sum2_q + 1'b1) : sum2_q;
      mag_b_q <= sum3_q[SUM_W-1] ? (~sum3_q + 1'b1) : sum3_q;
    end
    if (st_q == ST_MLO) begin
      pa_lo_q <= mag_a_q[31:0] * cnt3_q;
      pb_lo_q <= mag_b_q[31:0] * cnt2_q;
    end
    if (st_q == ST_MHI) begin
      pa_hi_q <= mag_a_q[SUM_W-1:32] * cnt3_q;
      pb_hi_q <= mag_b_q[SUM_W-1:32] * cnt2_q;
    end
    if (st_q == ST_SUM) begin
      pa_q <= WPROD_W'(pa_lo_q) + {pa_hi_q, 32'b0};
      pb_q <= WPROD_W'(pb_lo_q) + {pb_hi_q, 32'b0};
    end
    if (st_q == ST_CMP) begin
      pelvis_id_o      <= ID_W'(lab1_q);
      left_femur_id_o  <= swap ? ID_W'(lab3_q) : ID_W'(lab2_q);
      right_femur_id_o <= swap ? ID_W'(lab2_q) : ID_W'(lab3_q);
    end
  end

  // a last voxel locks out further voxels at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_voxel_i |=> busy_o)
    else $error("busy_o low after last voxel");

  // the scan owns the RAM port: no voxel may be in the pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SCAN |-> !a_v_q && !b_v_q && !c_v_q)
    else $error("voxel in flight during scan");

  // one result per volume, one cycle wide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // the result follows the compare step and finds all labels cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q == ST_CMP) && (vld_q == '0))
    else $error("result without compare or store not cleared");

endmodule

[rtl/core/lrcs_ram.sv]
module lrcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[test/tb_label_rank_and_centroid_sort_unit.sv]
module tb_label_rank_and_centroid_sort_unit;
  import lrcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] label;
    logic [9:0] ii;
    logic [9:0] jj;
    logic [9:0] kk;
    logic       last;
    int         gap;
  } voxel_t;

  typedef struct {
    logic [7:0] pelvis;
    logic [7:0] left;
    logic [7:0] right;
  } hip_ids_t;

  logic        clk_i, rst_ni;
  logic        start_i, busy_o;
  logic [7:0]  voxel_label_i;
  logic [9:0]  index_i_i, index_j_i, index_k_i;
  logic        last_voxel_i;
  logic        done_o;
  logic [7:0]  pelvis_id_o, left_femur_id_o, right_femur_id_o;
  logic        psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  label_rank_and_centroid_sort_unit DUT (.*);

  voxel_t   voxel_q[$];
  hip_ids_t ids_q[$];
  int       n_err = 0;
  int       n_sent = 0;
  logic     pause_req = 0;

  // predictor state
  logic signed [63:0] org_m, si_m, sj_m, sk_m;
  logic [29:0] cnt_m[NUM_LABELS];
  logic [63:0] sum_m[NUM_LABELS];

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int top_label(ref logic [29:0] w[NUM_LABELS]);
    int best;
    logic [29:0] bc;
    best = 0;
    bc = 0;
    for (int l = 1; l < NUM_LABELS; l++)
      if (w[l] > bc) begin
        bc = w[l];
        best = l;
      end
    return best;
  endfunction

  function automatic logic signed [127:0] wide_prod(logic [63:0] s, logic [29:0] c);
    return $signed(s) * $signed({98'd0, c});
  endfunction

  task automatic predict_voxel(voxel_t v);
    logic signed [63:0] x;
    logic [29:0] w[NUM_LABELS];
    int pel, lf, rf, t;
    logic [29:0] cl, cr;
    hip_ids_t h;
    x = org_m + $signed({54'd0, v.ii}) * si_m + $signed({54'd0, v.jj}) * sj_m
      + $signed({54'd0, v.kk}) * sk_m;
    if (cnt_m[v.label] != CNT_MAX) cnt_m[v.label]++;
    sum_m[v.label] += x;
    if (!v.last) return;
    w = cnt_m;
    w[0] = 0;
    pel = top_label(w);
    w[pel] = 0;
    lf = top_label(w);
    cl = w[lf];
    w[lf] = 0;
    rf = top_label(w);
    cr = w[rf];
    if (cl != 0 && cr != 0)
      if (wide_prod(sum_m[lf], cr) < wide_prod(sum_m[rf], cl)) begin
        t = lf;
        lf = rf;
        rf = t;
      end
    h.pelvis = pel[7:0];
    h.left = lf[7:0];
    h.right = rf[7:0];
    ids_q = {ids_q, h};
    for (int l = 0; l < NUM_LABELS; l++) begin
      cnt_m[l] = 0;
      sum_m[l] = 0;
    end
  endtask

  // driver
  int gap_cnt = 0;
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      predict_voxel(voxel_q[0]);
      void'(voxel_q.pop_front());
      n_sent++;
    end
    if (start_i && busy_o) begin
      // hold the beat
    end else if (gap_cnt > 0) begin
      gap_cnt <= gap_cnt - 1;
      start_i <= 0;
    end else if (voxel_q.size() > ((start_i && !busy_o) ? 0 : 0) && !pause_req) begin
      if (voxel_q[0].gap > 0 && !(start_i && !busy_o && 0)) begin
        gap_cnt <= voxel_q[0].gap - 1;
        voxel_q[0].gap = 0;
        start_i <= 0;
      end else begin
        start_i       <= 1;
        voxel_label_i <= voxel_q[0].label;
        index_i_i     <= voxel_q[0].ii;
        index_j_i     <= voxel_q[0].jj;
        index_k_i     <= voxel_q[0].kk;
        last_voxel_i  <= voxel_q[0].last;
      end
    end else begin
      start_i <= 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (ids_q.size() == 0) begin
        $error("unexpected result pelvis=%0d", pelvis_id_o);
        n_err++;
      end else begin
        if (pelvis_id_o !== ids_q[0].pelvis) begin
          $error("pelvis_id exp %0d got %0d", ids_q[0].pelvis, pelvis_id_o);
          n_err++;
        end
        if (left_femur_id_o !== ids_q[0].left) begin
          $error("left_femur_id exp %0d got %0d", ids_q[0].left, left_femur_id_o);
          n_err++;
        end
        if (right_femur_id_o !== ids_q[0].right) begin
          $error("right_femur_id exp %0d got %0d", ids_q[0].right, right_femur_id_o);
          n_err++;
        end
        void'(ids_q.pop_front());
      end
    end
  end

  task automatic wait_drain();
    while (voxel_q.size() != 0 || start_i) @(posedge clk_i);
    while (ids_q.size() != 0) @(posedge clk_i);
    repeat (NUM_LABELS + 40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_X_ORIGIN: org_m = $signed(val);
      REG_X_STEP_I: si_m = $signed(val);
      REG_X_STEP_J: sj_m = $signed(val);
      default:      sk_m = $signed(val);
    endcase
  endtask

  task automatic add_voxel(logic [7:0] l, logic [9:0] i, logic [9:0] j, logic [9:0] k,
                           logic last, int gap);
    voxel_t v;
    v.label = l;
    v.ii = i;
    v.jj = j;
    v.kk = k;
    v.last = last;
    v.gap = gap;
    voxel_q = {voxel_q, v};
  endtask

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // random volume: mode 1 draws mostly from four dominant labels, mode 0 from all labels
  task automatic add_volume(int n, int mode);
    logic [7:0] pool[4];
    for (int p = 0; p < 4; p++) pool[p] = 8'($urandom_range(0, 255));
    for (int v = 0; v < n; v++) begin
      logic [7:0] l;
      l = (mode == 0 || $urandom_range(0, 3) == 0) ? 8'($urandom()) :
          pool[$urandom_range(0, 3)];
      add_voxel(l, 10'($urandom()), 10'($urandom()), 10'($urandom()), v == n - 1,
                $urandom_range(0, 2) == 0 ? $urandom_range(0, 10) : 0);
    end
  endtask

  initial begin
    int sets;
    rst_ni = 0;
    start_i = 0;
    voxel_label_i = 0;
    index_i_i = 0;
    index_j_i = 0;
    index_k_i = 0;
    last_voxel_i = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    org_m = 0;
    si_m = 65536;
    sj_m = 0;
    sk_m = 0;
    for (int l = 0; l < NUM_LABELS; l++) begin
      cnt_m[l] = 0;
      sum_m[l] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty-ish volume, background only
    add_voxel(0, 0, 0, 0, 1, 0);
    // single label, too few labels
    add_voxel(5, 1023, 1023, 1023, 1, 0);
    // ties: lowest label wins, equal means keep rank order
    add_voxel(9, 3, 0, 0, 0, 0);
    add_voxel(4, 3, 0, 0, 0, 0);
    add_voxel(7, 3, 0, 0, 1, 0);
    // left/right swap on larger mean x
    add_voxel(200, 0, 0, 0, 0, 0);
    add_voxel(200, 0, 0, 0, 0, 0);
    add_voxel(200, 0, 0, 0, 0, 0);
    add_voxel(255, 10, 0, 0, 0, 0);
    add_voxel(255, 10, 0, 0, 0, 0);
    add_voxel(1, 1000, 0, 0, 0, 0);
    add_voxel(0, 0, 0, 0, 1, 0);
    wait_drain();

    reg_write(REG_X_ORIGIN, 32'h8000_0000);
    reg_write(REG_X_STEP_I, 32'h7FFF_FFFF);
    reg_write(REG_X_STEP_J, 32'h8000_0000);
    reg_write(REG_X_STEP_K, 32'h7FFF_FFFF);
    add_voxel(3, 1023, 0, 1023, 0, 0);
    add_voxel(3, 0, 1023, 0, 0, 0);
    add_voxel(2, 1023, 1023, 1023, 0, 0);
    add_voxel(8, 0, 1023, 0, 0, 0);
    add_voxel(8, 512, 0, 0, 1, 0);
    wait_drain();

    sets = 0;
    while (n_sent < 1450) begin
      if (sets % 6 == 0) begin
        wait_drain();
        reg_write(REG_X_ORIGIN, rand_step());
        reg_write(REG_X_STEP_I, rand_step());
        reg_write(REG_X_STEP_J, rand_step());
        reg_write(REG_X_STEP_K, rand_step());
      end
      add_volume($urandom_range(1, 40), sets % 5 == 4 ? 0 : 1);
      if (sets == 10) begin
        // hold off the sender until every queued volume has reported
        while (voxel_q.size() != 0) @(posedge clk_i);
        pause_req = 1;
        while (ids_q.size() != 0 || busy_o) @(posedge clk_i);
        pause_req = 0;
      end
      while (voxel_q.size() > 60) @(posedge clk_i);
      sets++;
    end
    wait_drain();
    if (n_err == 0)
      $display("label_rank_and_centroid_sort_unit: match");
    else
      $display("label_rank_and_centroid_sort_unit: mismatch");
    $finish;
  end

  initial begin
    #50ms;
    $display("label_rank_and_centroid_sort_unit: mismatch");
    $finish;
  end

endmodule
